FILE: rtl/clp_pkg.sv
// clp_pkg: shared types and character constants for the c-style integer literal parser
// no dependencies; used by the channel interfaces and the top level
package clp_pkg;

    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 64;
    localparam int CFG_W   = 4;

    // ascii codes that steer the parse
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
    localparam logic [CHAR_W-1:0] CH_F     = 8'h46;
    localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;
    localparam logic [CHAR_W-1:0] CASE_BIT = 8'h20;
    localparam logic [CHAR_W-1:0] HEX_OFS  = 8'd10;

    // supported result widths in bytes
    localparam logic [CFG_W-1:0] BYTES_1     = 4'd1;
    localparam logic [CFG_W-1:0] BYTES_2     = 4'd2;
    localparam logic [CFG_W-1:0] BYTES_4     = 4'd4;
    localparam logic [CFG_W-1:0] BYTES_8     = 4'd8;
    localparam logic [CFG_W-1:0] BYTES_RESET = BYTES_4;

    typedef enum logic [3:0] {
        PH_SIGN   = 4'b0001,
        PH_ZERO   = 4'b0010,
        PH_X      = 4'b0100,
        PH_DIGITS = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_OCT = 2'd1,
        RADIX_HEX = 2'd2
    } radix_t;

endpackage

FILE: rtl/clp_char_if.sv
// clp_char_if: character request channel (valid/ready plus character and start flag)
// depends on clp_pkg
interface clp_char_if import clp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              start_req;

    modport source (output valid, output char_code, output start_req, input ready);
    modport sink   (input valid, input char_code, input start_req, output ready);
endinterface

FILE: rtl/clp_result_if.sv
// clp_result_if: result request channel (valid/ready plus value, status, end flag)
// depends on clp_pkg
interface clp_result_if import clp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               status;
    logic               ended_on_nul;

    modport source (output valid, output value, output status, output ended_on_nul,
                    input ready);
    modport sink   (input valid, input value, input status, input ended_on_nul,
                    output ready);
endinterface

FILE: rtl/c_style_integer_literal_parser.sv
// c_style_integer_literal_parser: top level, input register, parse logic, result register
// depends on clp_pkg, clp_char_if, clp_result_if
// result path: the ending character passes the input register, then the result register
// throughput: one character per cycle while the result register is empty or being taken;
// each character needs an accumulator update (shift-add by the radix) before the next one
// reset: parse state cleared, width register set to 4 bytes, both channels empty
module c_style_integer_literal_parser
    import clp_pkg::*;
#(
    parameter int MAX_BYTES = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    clp_char_if.sink         chars,
    clp_result_if.source     results,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data
);

    localparam int ACC_W = MAX_BYTES * 8;

    logic [CFG_W-1:0]  value_bytes_reg;

    // input stage
    logic              s1_valid_reg;
    logic [CHAR_W-1:0] s1_char_reg;
    logic              s1_start_reg;
    logic              s1_adv;

    // parse state
    phase_t            phase_reg, phase_next;
    logic              neg_reg, neg_next;
    radix_t            radix_reg, radix_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;

    // result stage
    logic               res_valid_reg, res_valid_next;
    logic [VALUE_W-1:0] res_value_reg;
    logic               res_status_reg;
    logic               res_nul_reg;

    // combinational parse
    phase_t            ph;
    logic              neg;
    radix_t            rad;
    logic [ACC_W-1:0]  acc;
    logic [ACC_W-1:0]  mask;
    logic [ACC_W-1:0]  scaled;
    logic [ACC_W-1:0]  result;
    logic [CHAR_W-1:0] upper;
    logic [CHAR_W-1:0] hex_val;
    logic [6:0]        width_bits;
    logic              width_ok;
    logic              is_sign;
    logic              is_dec;
    logic              is_hex_letter;
    logic              term;

    assign s1_adv      = s1_valid_reg && (!res_valid_reg || results.ready);
    assign chars.ready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        width_ok = (32'(value_bytes_reg) <= MAX_BYTES) &&
                   (value_bytes_reg == BYTES_1 || value_bytes_reg == BYTES_2 ||
                    value_bytes_reg == BYTES_4 || value_bytes_reg == BYTES_8);
        width_bits = {value_bytes_reg, 3'b000};
        for (int i = 0; i < ACC_W; i++)
        begin
            mask[i] = !width_ok || (i < 32'(width_bits));
        end
    end

    always_comb
    begin
        ph  = s1_start_reg ? PH_SIGN : phase_reg;
        neg = s1_start_reg ? 1'b0 : neg_reg;
        rad = s1_start_reg ? RADIX_DEC : radix_reg;
        acc = s1_start_reg ? '0 : acc_reg;

        upper         = s1_char_reg & ~CASE_BIT;
        hex_val       = upper - CH_A + HEX_OFS;
        is_sign       = (s1_char_reg == CH_PLUS) || (s1_char_reg == CH_MINUS);
        is_dec        = (s1_char_reg >= CH_0) && (s1_char_reg <= CH_9);
        is_hex_letter = (rad == RADIX_HEX) && (upper >= CH_A) && (upper <= CH_F);

        case (rad)
            RADIX_HEX: scaled = acc << 4;
            RADIX_OCT: scaled = acc << 3;
            default:   scaled = (acc << 3) + (acc << 1);
        endcase

        phase_next = ph;
        neg_next   = neg;
        radix_next = rad;
        acc_next   = acc;
        term       = 1'b0;

        if (ph == PH_SIGN && is_sign)
        begin
            phase_next = PH_ZERO;
            neg_next   = (s1_char_reg == CH_MINUS);
        end
        else if ((ph == PH_SIGN || ph == PH_ZERO) && s1_char_reg == CH_0)
        begin
            phase_next = PH_X;
            radix_next = RADIX_OCT;
        end
        else if (ph != PH_DIGITS && (s1_char_reg == CH_X_LO || s1_char_reg == CH_X_UP))
        begin
            phase_next = PH_DIGITS;
            radix_next = RADIX_HEX;
        end
        else
        begin
            phase_next = PH_DIGITS;
            if (is_dec)
            begin
                acc_next = (scaled + ACC_W'(s1_char_reg - CH_0)) & mask;
            end
            else if (is_hex_letter)
            begin
                acc_next = ((acc << 4) + ACC_W'(hex_val[3:0])) & mask;
            end
            else
            begin
                term = 1'b1;
            end
        end

        result = acc & mask;
        if (neg)
        begin
            result = (ACC_W'(0) - result) & mask;
        end

        // the ending character is consumed; parse restarts from idle
        if (term)
        begin
            phase_next = PH_SIGN;
            neg_next   = 1'b0;
            radix_next = RADIX_DEC;
            acc_next   = '0;
        end
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (s1_adv)
        begin
            res_valid_next = term;
        end
        else if (results.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_bytes_reg <= BYTES_RESET;
            s1_valid_reg    <= 1'b0;
            phase_reg       <= PH_SIGN;
            neg_reg         <= 1'b0;
            radix_reg       <= RADIX_DEC;
            acc_reg         <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                value_bytes_reg <= cfg_wr_data;
            end
            if (chars.ready)
            begin
                s1_valid_reg <= chars.valid;
            end
            if (s1_adv)
            begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                radix_reg <= radix_next;
                acc_reg   <= acc_next;
            end
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            s1_char_reg  <= chars.char_code;
            s1_start_reg <= chars.start_req;
        end
        if (s1_adv && term)
        begin
            res_value_reg  <= width_ok ? VALUE_W'(result) : '0;
            res_status_reg <= !width_ok;
            res_nul_reg    <= (s1_char_reg == CH_NUL);
        end
    end

    assign results.valid        = res_valid_reg;
    assign results.value        = res_value_reg;
    assign results.status       = res_status_reg;
    assign results.ended_on_nul = res_nul_reg;

    // an ending character always produces a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && term |=> res_valid_reg)
        else $error("ending character did not produce a result");

    // parse state is back to idle after a number ends
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && term |=> (acc_reg == '0) && (phase_reg == PH_SIGN) && !neg_reg)
        else $error("parse state not cleared after a result");

    // an unsupported width always reports a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_status_reg |-> (res_value_reg == '0))
        else $error("flagged result carries a nonzero value");

    // a held input stage blocks new characters
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |-> !chars.ready)
        else $error("character taken while input stage is stalled");

    // a waiting result stays unchanged until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !results.ready |=> res_valid_reg && $stable(res_value_reg))
        else $error("stalled result was lost or changed");

endmodule

FILE: sim/tb_c_style_integer_literal_parser.sv
// testbench for c_style_integer_literal_parser: drives ascii characters, checks every parsed
// number against a parser model or fixed row; depends on clp_pkg, clp_char_if, clp_result_if
`timescale 1ns / 1ps

module tb_c_style_integer_literal_parser;
    import clp_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int SETTLE_CYCLES   = 8;
    localparam int CHARS_PER_PHASE = 110;
    localparam int LONG_HOLD       = 100;
    localparam int HOLD_AT_RESULT  = 20;
    localparam int NUM_DIRECTED    = 27;
    localparam int NUM_PHASES      = 7;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               status;
        logic               ended_on_nul;
    } parse_result_t;

    typedef struct packed {
        logic [CHAR_W-1:0]  ch;
        logic               start;
        logic               fixed;
        logic [VALUE_W-1:0] value;
        logic               status;
        logic               ended_on_nul;
    } char_row_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;

    clp_char_if   char_ch();
    clp_result_if result_ch();

    c_style_integer_literal_parser u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .chars       (char_ch),
        .results     (result_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // parser model state
    logic [CFG_W-1:0]   width_bytes = BYTES_RESET;
    phase_t             parse_phase = PH_SIGN;
    logic               is_negative = 1'b0;
    radix_t             radix       = RADIX_DEC;
    logic [VALUE_W-1:0] accum       = '0;

    parse_result_t expected_results[$];
    int            tx_idle_pct     = 0;
    int            rx_idle_pct     = 0;
    int            errors          = 0;
    int            chars_sent      = 0;
    int            results_checked = 0;

    // width 4 (reset); fixed rows carry a hand-written result, others use the model
    char_row_t directed_rows [NUM_DIRECTED] = '{
        '{CH_NUL,   1'b1, 1'b1, 64'h0,         1'b0, 1'b1},
        '{CH_MINUS, 1'b1, 1'b0, 64'h0,         1'b0, 1'b0},
        '{CH_NUL,   1'b0, 1'b1, 64'h0,         1'b0, 1'b1},
        '{CH_0,     1'b1, 1'b0, 64'h0,         1'b0, 1'b0},
        '{CH_X_LO,  1'b0, 1'b0, 64'h0,         1'b0, 1'b0},
        '{CH_NUL,   1'b0, 1'b1, 64'h0,         1'b0, 1'b1},
        '{CH_MINUS, 1'b1, 1'b0, 64'h0,         1'b0, 1'b0},
        '{"1",      1'b0, 1'b0, 64'h0,         1'b0, 1'b0},
        '{"z",      1'b0, 1'b1, 64'hFFFF_FFFF, 1'b0, 1'b0},
        '{CH_0,     1'b1, 1'b0, 64'h0,         1'b0, 1'b0},
        '{"1",      1'b0, 1'b0, 64'h0,         1'b0, 1'b0},
        '{CH_9,     1'b0, 1'b0, 64'h0,         1'b0, 1'b0},
        '{CH_NUL,   1'b0, 1'b0, 64'h0,         1'b0, 1'b0},
        '{CH_PLUS,  1'b1, 1'b0, 64'h0,         1'b0, 1'b0},
        '{CH_0,     1'b0, 1'b0, 64'h0,         1'b0, 1'b0},
        '{CH_X_UP,  1'b0, 1'b0, 64'h0,         1'b0, 1'b0},
        '{"a",      1'b0, 1'b0, 64'h0,         1'b0, 1'b0},
        '{CH_F,     1'b0, 1'b0, 64'h0,         1'b0, 1'b0},
        '{"g",      1'b0, 1'b0, 64'h0,         1'b0, 1'b0},
        '{8'hFF,    1'b1, 1'b1, 64'h0,         1'b0, 1'b0},
        '{"5",      1'b1, 1'b0, 64'h0,         1'b0, 1'b0},
        '{"7",      1'b1, 1'b0, 64'h0,         1'b0, 1'b0},
        '{":",      1'b0, 1'b0, 64'h0,         1'b0, 1'b0},
        '{"@",      1'b1, 1'b1, 64'h0,         1'b0, 1'b0},
        '{CH_X_UP,  1'b1, 1'b0, 64'h0,         1'b0, 1'b0},
        '{"1",      1'b0, 1'b0, 64'h0,         1'b0, 1'b0},
        '{CH_NUL,   1'b0, 1'b0, 64'h0,         1'b0, 1'b0}
    };

    logic [CFG_W-1:0] phase_widths [NUM_PHASES] =
        '{BYTES_1, BYTES_8, 4'd0, BYTES_2, 4'd15, 4'd3, BYTES_4};

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // advance the parser model by one character
    task automatic parse_char(input logic [CHAR_W-1:0] c, input logic start,
                              output bit fired, output parse_result_t res);
        logic [VALUE_W-1:0] mask;
        logic [VALUE_W-1:0] base;
        logic [VALUE_W-1:0] num;
        logic [CHAR_W-1:0]  upper;
        bit                 taken;
        bit                 width_ok;

        fired    = 1'b0;
        res      = '0;
        taken    = 1'b0;
        upper    = c & ~CASE_BIT;
        width_ok = (width_bytes == BYTES_1) || (width_bytes == BYTES_2) ||
                   (width_bytes == BYTES_4) || (width_bytes == BYTES_8);
        case (width_bytes)
            BYTES_1: mask = 64'hFF;
            BYTES_2: mask = 64'hFFFF;
            BYTES_4: mask = 64'hFFFF_FFFF;
            default: mask = '1;
        endcase
        if (start)
        begin
            parse_phase = PH_SIGN;
            is_negative = 1'b0;
            radix       = RADIX_DEC;
            accum       = '0;
        end
        if (parse_phase == PH_SIGN)
        begin
            parse_phase = PH_ZERO;
            if (c == CH_PLUS || c == CH_MINUS)
            begin
                is_negative = (c == CH_MINUS);
                taken       = 1'b1;
            end
        end
        if (!taken && parse_phase == PH_ZERO)
        begin
            parse_phase = PH_X;
            if (c == CH_0)
            begin
                radix = RADIX_OCT;
                taken = 1'b1;
            end
        end
        if (!taken && parse_phase == PH_X)
        begin
            parse_phase = PH_DIGITS;
            if (c == CH_X_UP || c == CH_X_LO)
            begin
                radix = RADIX_HEX;
                taken = 1'b1;
            end
        end
        base = (radix == RADIX_HEX) ? 64'd16 : ((radix == RADIX_OCT) ? 64'd8 : 64'd10);
        if (!taken && c != CH_NUL)
        begin
            // octal still takes 8 and 9 as digit values
            if (c >= CH_0 && c <= CH_9)
            begin
                accum = (accum * base + VALUE_W'(c - CH_0)) & mask;
                taken = 1'b1;
            end
            else if (radix == RADIX_HEX && upper >= CH_A && upper <= CH_F)
            begin
                accum = ((accum << 4) + VALUE_W'(upper - CH_A + HEX_OFS)) & mask;
                taken = 1'b1;
            end
        end
        if (!taken)
        begin
            num = accum & mask;
            if (is_negative)
                num = (64'd0 - num) & mask;
            res.value        = width_ok ? num : '0;
            res.status       = !width_ok;
            res.ended_on_nul = (c == CH_NUL);
            fired            = 1'b1;
            parse_phase      = PH_SIGN;
            is_negative      = 1'b0;
            radix            = RADIX_DEC;
            accum            = '0;
        end
    endtask

    // offer one character, wait for the request to be taken, log what it should produce
    task automatic push_char(input logic [CHAR_W-1:0] c, input logic start,
                             input bit use_fixed, input parse_result_t fixed_res);
        bit            fired;
        parse_result_t res;

        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            char_ch.valid <= 1'b0;
            @(posedge clk);
        end
        char_ch.valid     <= 1'b1;
        char_ch.char_code <= c;
        char_ch.start_req <= start;
        @(posedge clk);
        while (!char_ch.ready)
            @(posedge clk);
        parse_char(c, start, fired, res);
        if (use_fixed)
            expected_results.push_back(fixed_res);
        else if (fired)
            expected_results.push_back(res);
        chars_sent++;
    endtask

    task automatic wait_drained();
        char_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // result side: random back-pressure, one long hold, and the scoreboard check
    initial
    begin
        int            hold_left;
        parse_result_t got;
        parse_result_t want;

        hold_left = 0;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
            begin
                got.value        = result_ch.value;
                got.status       = result_ch.status;
                got.ended_on_nul = result_ch.ended_on_nul;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result: value %h status %0d nul %0d",
                             $time, got.value, got.status, got.ended_on_nul);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.value !== want.value)
                    begin
                        $display("%0t: value mismatch: expected %h actual %h",
                                 $time, want.value, got.value);
                        errors++;
                    end
                    if (got.status !== want.status)
                    begin
                        $display("%0t: status mismatch: expected %0d actual %0d",
                                 $time, want.status, got.status);
                        errors++;
                    end
                    if (got.ended_on_nul !== want.ended_on_nul)
                    begin
                        $display("%0t: ended_on_nul mismatch: expected %0d actual %0d",
                                 $time, want.ended_on_nul, got.ended_on_nul);
                        errors++;
                    end
                end
                results_checked++;
                if (results_checked == HOLD_AT_RESULT)
                    hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial
    begin
        logic [CHAR_W-1:0] lit[$];
        logic [CHAR_W-1:0] term;
        int                prefix;
        int                ndig;
        int                pick;
        int                sent_in_phase;
        radix_t            lit_radix;

        rst_n             <= 1'b0;
        cfg_wr_en         <= 1'b0;
        cfg_wr_data       <= '0;
        char_ch.valid     <= 1'b0;
        char_ch.char_code <= '0;
        char_ch.start_req <= 1'b0;
        tx_idle_pct = 36;
        rx_idle_pct = 55;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            push_char(directed_rows[i].ch, directed_rows[i].start, directed_rows[i].fixed,
                      '{directed_rows[i].value, directed_rows[i].status,
                        directed_rows[i].ended_on_nul});

        foreach (phase_widths[p])
        begin
            // leave a number open across the width change
            push_char(CH_MINUS, 1'b1, 1'b0, '0);
            push_char(8'(CH_0 + $urandom_range(1, 9)), 1'b0, 1'b0, '0);
            wait_drained();
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= phase_widths[p];
            @(posedge clk);
            cfg_wr_en   <= 1'b0;
            width_bytes = phase_widths[p];
            if (p < 3)
            begin
                tx_idle_pct = 36;
                rx_idle_pct = 55;
            end
            else if (p < 5)
            begin
                tx_idle_pct = 55;
                rx_idle_pct = 36;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            push_char(CH_9, 1'b0, 1'b0, '0);
            push_char(CH_NUL, 1'b0, 1'b0, '0);

            sent_in_phase = 0;
            while (sent_in_phase < CHARS_PER_PHASE)
            begin
                if ($urandom_range(9) == 0)
                begin
                    push_char(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
                    sent_in_phase++;
                end
                else
                begin
                    lit.delete();
                    case ($urandom_range(2))
                        1: lit.push_back(CH_PLUS);
                        2: lit.push_back(CH_MINUS);
                        default: ;
                    endcase
                    prefix    = $urandom_range(4);
                    lit_radix = (prefix == 0) ? RADIX_DEC :
                                ((prefix == 1) ? RADIX_OCT : RADIX_HEX);
                    if (prefix >= 1 && prefix <= 3)
                        lit.push_back(CH_0);
                    if (prefix == 2 || prefix == 4)
                        lit.push_back(CH_X_LO);
                    if (prefix == 3)
                        lit.push_back(CH_X_UP);
                    // mostly short numbers, now and then long enough to wrap 64 bits
                    ndig = ($urandom_range(7) == 0) ? $urandom_range(24) : $urandom_range(8);
                    repeat (ndig)
                    begin
                        if (lit_radix == RADIX_HEX)
                        begin
                            pick = $urandom_range(21);
                            if (pick < 10)
                                lit.push_back(8'(CH_0 + pick));
                            else if (pick < 16)
                                lit.push_back(8'(CH_A + pick - 10));
                            else
                                lit.push_back(8'((CH_A | CASE_BIT) + pick - 16));
                        end
                        else
                            lit.push_back(8'(CH_0 + $urandom_range(9)));
                    end
                    if ($urandom_range(3) != 0)
                        term = CH_NUL;
                    else
                        do
                            term = 8'($urandom_range(1, 255));
                        while ((term >= CH_0 && term <= CH_9) ||
                               ((term & ~CASE_BIT) >= CH_A && (term & ~CASE_BIT) <= CH_F) ||
                               (term & ~CASE_BIT) == CH_X_UP ||
                               term == CH_PLUS || term == CH_MINUS);
                    lit.push_back(term);
                    foreach (lit[k])
                    begin
                        // occasional restart in the middle of a number
                        push_char(lit[k],
                                  (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(29) == 0),
                                  1'b0, '0);
                    end
                    sent_in_phase += lit.size();
                end
            end
        end

        wait_drained();
        $display("covered %0d characters and %0d parsed numbers over widths 4, 1, 8, 0, 2, 15, 3, 4",
                 chars_sent, results_checked);
        $display("with signs, octal and hex prefixes, wraparound, restarts and %0d mismatches",
                 errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("FAILURE");
        $finish;
    end

endmodule
